// ===== rtl/core/fwtt_pkg.sv =====
package fwtt_pkg;

	localparam int TAG_W   = 16;
	localparam int KEY_W   = 64;
	localparam int META_W  = 35;
	localparam int PAY_W   = 64;
	localparam logic signed [15:0] SCORE_MAX = 16'sd32760;
	localparam logic signed [15:0] SCORE_MIN = -16'sd32760;

	typedef enum logic [1:0] {
		OP_PROBE  = 2'd0,
		OP_STORE  = 2'd1,
		OP_NEWSRC = 2'd2,
		OP_NOP    = 2'd3
	} op_t;

	localparam logic [1:0] BOUND_NONE  = 2'd0;
	localparam logic [1:0] BOUND_UPPER = 2'd1;
	localparam logic [1:0] BOUND_LOWER = 2'd2;
	localparam logic [1:0] BOUND_EXACT = 2'd3;

	typedef struct packed {
		logic [1:0]         operation;
		logic [63:0]        position_key;
		logic signed [7:0]  search_depth;
		logic signed [15:0] window_low;
		logic signed [15:0] window_high;
		logic signed [15:0] new_score;
		logic signed [15:0] new_eval;
		logic [1:0]         new_bound;
		logic [31:0]        new_move;
		logic               new_is_pv;
	} req_t;

	typedef struct packed {
		logic               found;
		logic               cutoff;
		logic signed [15:0] stored_score;
		logic signed [15:0] stored_eval;
		logic [31:0]        stored_move;
		logic               stored_pv;
	} rsp_t;

	// replacement score: fits in 11 signed bits (2*255 + 36)
	function automatic logic signed [10:0] repl_score(input logic [META_W-1:0] m,
			input logic signed [7:0] depth, input logic [7:0] age);
		logic signed [10:0] s;
		s = (m[34:27] == age) ? 11'sd0 : 11'sd32;
		s = s + 11'(2 * (11'(depth) - 11'($signed(m[23:16]))));
		s = s + ((m[25:24] == BOUND_EXACT) ? 11'sd0 : 11'sd4);
		s = s - (m[26] ? 11'sd2 : 11'sd0);
		return s;
	endfunction

	function automatic logic signed [15:0] clamp(input logic signed [15:0] v);
		if (v > SCORE_MAX) return SCORE_MAX;
		if (v < SCORE_MIN) return SCORE_MIN;
		return v;
	endfunction

endpackage

// ===== rtl/core/fwtt_if.sv =====
interface fwtt_req_if;
	import fwtt_pkg::*;
	logic valid;
	logic ready;
	req_t data;
	modport source (output valid, output data, input ready);
	modport sink (input valid, input data, output ready);
endinterface

interface fwtt_rsp_if;
	import fwtt_pkg::*;
	logic valid;
	logic ready;
	rsp_t data;
	modport source (output valid, output data, input ready);
	modport sink (input valid, input data, output ready);
endinterface

// ===== rtl/core/fwtt_front.sv =====
module fwtt_front #(
	parameter int DEPTH = 2
) (
	input  logic clk,
	input  logic arst_n,
	fwtt_req_if.sink in_ch,
	input  logic pop,
	output logic avail,
	output fwtt_pkg::req_t head
);
	import fwtt_pkg::*;

	localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;

	req_t q_mem [DEPTH];
	logic [PW-1:0] wp_q, rp_q;
	logic [PW:0] cnt_q;
	logic push;
	req_t cln;

	assign in_ch.ready = (cnt_q != (PW+1)'(DEPTH));
	assign push = in_ch.valid && in_ch.ready;
	assign avail = (cnt_q != '0);
	assign head = q_mem[rp_q];

	// classify: clamp payload at entry
	always_comb begin
		cln = in_ch.data;
		cln.new_score = clamp(in_ch.data.new_score);
		cln.new_eval = clamp(in_ch.data.new_eval);
	end

	always_ff @(posedge clk) begin
		if (push) q_mem[wp_q] <= cln;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wp_q <= '0;
			rp_q <= '0;
			cnt_q <= '0;
		end else begin
			if (push) wp_q <= (wp_q == PW'(DEPTH-1)) ? '0 : wp_q + 1'b1;
			if (pop) rp_q <= (rp_q == PW'(DEPTH-1)) ? '0 : rp_q + 1'b1;
			cnt_q <= cnt_q + (PW+1)'(push) - (PW+1)'(pop);
		end
	end
endmodule

// ===== rtl/core/fwtt_back.sv =====
module fwtt_back #(
	parameter int CLUSTER_COUNT = 1024,
	parameter int WAYS = 4
) (
	input  logic clk,
	input  logic arst_n,
	input  logic avail,
	input  fwtt_pkg::req_t head,
	output logic pop,
	fwtt_rsp_if.source out_ch
);
	import fwtt_pkg::*;

	localparam int CW = (CLUSTER_COUNT > 1) ? $clog2(CLUSTER_COUNT) : 1;
	localparam int WW = (WAYS > 1) ? $clog2(WAYS) : 1;

	typedef enum logic [3:0] {
		ST_CLR  = 4'b0001,
		ST_IDLE = 4'b0010,
		ST_RD   = 4'b0100,
		ST_OUT  = 4'b1000
	} st_t;

	// one wide row per cluster: all ways read and written together
	logic [WAYS*META_W-1:0] meta_mem [CLUSTER_COUNT];
	logic [WAYS*PAY_W-1:0]  pay_mem  [CLUSTER_COUNT];
	logic [WAYS*META_W-1:0] meta_rd_q;
	logic [WAYS*PAY_W-1:0]  pay_rd_q;

	st_t st_q;
	logic [CW-1:0] clr_q;
	logic [7:0] age_q;
	req_t req_q;
	logic [CW-1:0] cl_q;
	rsp_t rsp_q;

	logic [CW-1:0] rd_idx;
	logic wr_en;
	logic [CW-1:0] wr_idx;
	logic [WAYS*META_W-1:0] meta_wr;
	logic [WAYS*PAY_W-1:0]  pay_wr;
	rsp_t rsp_d;

	assign rd_idx = CW'(head.position_key % 64'(CLUSTER_COUNT));
	assign pop = (st_q == ST_IDLE) && avail && !out_ch.valid;
	assign out_ch.valid = (st_q == ST_OUT);
	assign out_ch.data = rsp_q;

	// cluster read and write ports
	always_ff @(posedge clk) begin
		if (pop) begin
			meta_rd_q <= meta_mem[rd_idx];
			pay_rd_q <= pay_mem[rd_idx];
		end
		if (wr_en) begin
			meta_mem[wr_idx] <= meta_wr;
			pay_mem[wr_idx] <= pay_wr;
		end
	end

	// decide probe hit / store victim over the read cluster; also drive the clearing writes
	always_comb begin
		logic [TAG_W-1:0] tag;
		logic [META_W-1:0] m, rm;
		logic hit, stop;
		logic [WW-1:0] hw, rw;
		logic signed [10:0] best, s;
		logic signed [15:0] sc;
		logic cut;
		tag = req_q.position_key[63:48];
		hit = 1'b0;
		hw = '0;
		stop = 1'b0;
		rw = '0;
		rm = '0;
		s = '0;
		sc = '0;
		cut = 1'b0;
		best = repl_score(meta_rd_q[META_W-1:0], req_q.search_depth, age_q);
		for (int i = 0; i < WAYS; i++) begin
			m = meta_rd_q[i*META_W +: META_W];
			if (!hit && m[15:0] == tag && m[25:24] != BOUND_NONE) begin
				hit = 1'b1;
				hw = WW'(i);
			end
			if (!stop) begin
				if (m[15:0] == tag || m[25:24] == BOUND_NONE) begin
					stop = 1'b1;
					rw = WW'(i);
				end else begin
					s = repl_score(m, req_q.search_depth, age_q);
					if (s > best) begin
						best = s;
						rw = WW'(i);
					end
				end
			end
		end
		rsp_d = '0;
		wr_en = 1'b0;
		wr_idx = cl_q;
		meta_wr = meta_rd_q;
		pay_wr = pay_rd_q;
		if (st_q == ST_CLR) begin
			wr_en = 1'b1;
			wr_idx = clr_q;
			meta_wr = '0;
			pay_wr = '0;
		end else if (st_q == ST_RD) begin
			case (req_q.operation)
				OP_PROBE: begin
					if (hit) begin
						m = meta_rd_q[hw*META_W +: META_W];
						sc = $signed(pay_rd_q[hw*PAY_W +: 16]);
						cut = 1'b0;
						if ($signed(m[23:16]) >= req_q.search_depth) begin
							if (m[25:24] == BOUND_EXACT) cut = 1'b1;
							else if (m[25:24] == BOUND_LOWER && sc >= req_q.window_high)
								cut = 1'b1;
							else if (m[25:24] == BOUND_UPPER && sc <= req_q.window_low)
								cut = 1'b1;
						end
						rsp_d.found = 1'b1;
						rsp_d.cutoff = cut;
						rsp_d.stored_score = cut ? sc : 16'sd0;
						rsp_d.stored_eval = $signed(pay_rd_q[hw*PAY_W+16 +: 16]);
						rsp_d.stored_move = pay_rd_q[hw*PAY_W+32 +: 32];
						rsp_d.stored_pv = m[26];
						wr_en = 1'b1;
						meta_wr[hw*META_W+27 +: 8] = age_q;
					end
				end
				OP_STORE: begin
					rm = meta_rd_q[rw*META_W +: META_W];
					if (!(rm[15:0] == tag && rm[25:24] == BOUND_EXACT &&
							$signed(rm[23:16]) > req_q.search_depth &&
							req_q.new_bound != BOUND_EXACT)) begin
						wr_en = 1'b1;
						meta_wr[rw*META_W +: META_W] = {age_q, req_q.new_is_pv,
							req_q.new_bound, req_q.search_depth, tag};
						pay_wr[rw*PAY_W +: PAY_W] = {req_q.new_move, req_q.new_eval,
							req_q.new_score};
					end
				end
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (pop) begin
			req_q <= head;
			cl_q <= rd_idx;
		end
		if (st_q == ST_RD) rsp_q <= rsp_d;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q <= ST_CLR;
			clr_q <= '0;
			age_q <= '0;
		end else begin
			case (st_q)
				ST_CLR: begin
					clr_q <= clr_q + 1'b1;
					if (clr_q == CW'(CLUSTER_COUNT-1)) st_q <= ST_IDLE;
				end
				ST_IDLE: if (pop) st_q <= ST_RD;
				ST_RD: begin
					if (req_q.operation == OP_NEWSRC) age_q <= age_q + 1'b1;
					st_q <= ST_OUT;
				end
				ST_OUT: if (out_ch.ready) st_q <= ST_IDLE;
				default: st_q <= ST_IDLE;
			endcase
		end
	end
endmodule

// ===== rtl/core/four_way_transposition_table_unit.sv =====
// Path: an input transfer is queued, popped with the cluster read, then decided before result valid.
// Items go one at a time through the idle/pop, read-modify-write and output states.
// Reset: asynchronous active-low; then a clearing pass writes CLUSTER_COUNT rows,
// one per cycle, before the first item executes.
// Input transfers are queued in a 2-entry queue during the clearing pass.
module four_way_transposition_table_unit #(
	parameter int CLUSTER_COUNT = 1024,
	parameter int WAYS = 4
) (
	input logic clk,
	input logic arst_n,
	fwtt_req_if.sink in_ch,
	fwtt_rsp_if.source out_ch
);
	import fwtt_pkg::*;

	logic pop, avail;
	req_t head;

	fwtt_front #(.DEPTH(2)) u_front (
		.clk(clk), .arst_n(arst_n), .in_ch(in_ch),
		.pop(pop), .avail(avail), .head(head)
	);

	fwtt_back #(.CLUSTER_COUNT(CLUSTER_COUNT), .WAYS(WAYS)) u_back (
		.clk(clk), .arst_n(arst_n), .avail(avail), .head(head),
		.pop(pop), .out_ch(out_ch)
	);
endmodule
